// File: src/mds4_pkg.sv
// ----------------------------------------------------------------------------
// mds4_pkg
// Shared constants and helpers for the four-point least distance sum engine.
// ----------------------------------------------------------------------------
package mds4_pkg;

  localparam int NUM_PTS   = 4;
  localparam int NUM_PAIRS = 3;
  localparam int NUM_CANDS = NUM_PTS + NUM_PAIRS;

  // point indices a, b, c, d of line pair p: lines a-b and c-d
  function automatic int pair_pt(input int p, input int k);
    int idx;
    idx = 0;
    unique case (p * NUM_PTS + k)
      0:  idx = 0;
      1:  idx = 1;
      2:  idx = 2;
      3:  idx = 3;
      4:  idx = 0;
      5:  idx = 2;
      6:  idx = 1;
      7:  idx = 3;
      8:  idx = 0;
      9:  idx = 3;
      10: idx = 2;
      11: idx = 1;
      default: idx = 0;
    endcase
    return idx;
  endfunction

  // pipeline depth of the distance sum unit: deltas, squares, sum, one stage
  // per root bit, two adder stages
  function automatic int dsum_lat(input int coord_bits);
    return coord_bits + 6;
  endfunction

endpackage

// File: src/mds4_if.sv
// ----------------------------------------------------------------------------
// mds4 channel interfaces
// Valid/ready channels for the point set input and the distance result.
// ----------------------------------------------------------------------------
interface mds4_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x0;
  logic signed [COORD_BITS-1:0] y0;
  logic signed [COORD_BITS-1:0] x1;
  logic signed [COORD_BITS-1:0] y1;
  logic signed [COORD_BITS-1:0] x2;
  logic signed [COORD_BITS-1:0] y2;
  logic signed [COORD_BITS-1:0] x3;
  logic signed [COORD_BITS-1:0] y3;

  modport source (output valid, x0, y0, x1, y1, x2, y2, x3, y3, input ready);
  modport sink   (input valid, x0, y0, x1, y1, x2, y2, x3, y3, output ready);
endinterface

interface mds4_out_if #(
  parameter int COORD_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS+2:0] total_distance;

  modport source (output valid, total_distance, input ready);
  modport sink   (input valid, total_distance, output ready);
endinterface

// File: src/min_distance_sum_four_points.sv
// ----------------------------------------------------------------------------
// min_distance_sum_four_points
// Least total distance from a candidate point to four points; candidates are
// the points and the crossings of the three line pairs.
// ----------------------------------------------------------------------------
//  channel | dir | payload                      | transaction
//  in_ch   | in  | x0 y0 x1 y1 x2 y2 x3 y3      | one point set
//  out_ch  | out | total_distance               | one least distance sum
//
//  one transaction per cycle in and out unless a waiting result stalls out_ch;
//  the pipeline depth is set by the crossing divider (one quotient bit per
//  stage) and the square root (one bit per stage).
//  rst_n clears only the valid bits of the pipeline.
//  the pipeline moves as a whole: it holds when a result waits and out_ch is
//  not ready, and empty stages never block input.
// ----------------------------------------------------------------------------
module min_distance_sum_four_points #(
  parameter int COORD_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  mds4_in_if.sink    in_ch,
  mds4_out_if.source out_ch
);
  import mds4_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int W      = C + 1;          // coordinate difference
  localparam int X      = 2 * W + 1;      // cross product
  localparam int TL     = (X + 1) / 2;
  localparam int TH     = X - TL;
  localparam int PW     = W + X;          // |delta| * |t|
  localparam int DW     = X + 1;          // divisor 2*|den|
  localparam int QB     = C + 3;          // quotient bits
  localparam int RW     = DW + QB;        // partial remainder
  localparam int VW     = QB + 2;
  localparam int SW     = C + 3;
  localparam int NL     = 2 * NUM_PAIRS;  // one lane per pair and axis
  localparam int DL     = dsum_lat(C);
  localparam int V_CAND = QB + 5;
  localparam int V_DS   = V_CAND + DL;
  localparam int V_OUT  = V_DS + 2;

  localparam logic [QB-1:0]        QLIM = QB'(2 ** (C + 1));
  localparam logic signed [VW-1:0] VMIN = VW'(-(2 ** (C - 1)));
  localparam logic signed [VW-1:0] VMAX = VW'(2 ** (C - 1) - 1);

  typedef logic signed [C-1:0] crd_t;

  logic           adv;
  logic [V_OUT:0] vld_r;

  crd_t pdx_r [V_CAND+1][NUM_PTS];
  crd_t pdy_r [V_CAND+1][NUM_PTS];

  logic signed [X-1:0] den1_r [NUM_PAIRS];
  logic signed [X-1:0] den1_nxt [NUM_PAIRS];
  logic signed [X-1:0] t1_r [NUM_PAIRS];
  logic signed [X-1:0] t1_nxt [NUM_PAIRS];
  logic signed [W-1:0] dl1_r [NL];
  logic signed [W-1:0] dl1_nxt [NL];
  crd_t                bs1_r [NL];
  crd_t                bs1_nxt [NL];

  logic [W+TL-1:0] pl2_r [NL];
  logic [W+TL-1:0] pl2_nxt [NL];
  logic [W+TH-1:0] ph2_r [NL];
  logic [W+TH-1:0] ph2_nxt [NL];
  logic [X-1:0]    dm2_r [NL];
  logic [X-1:0]    dm2_nxt [NL];
  logic [NL-1:0]   ng2_r;
  logic [NL-1:0]   ng2_nxt;
  logic [NL-1:0]   nz2_r;
  logic [NL-1:0]   nz2_nxt;
  crd_t            bs2_r [NL];

  logic [RW-1:0] rem_r [NL][QB+1];
  logic [RW-1:0] rem_nxt [NL][QB+1];
  logic [DW-1:0] dv_r [NL][QB+1];
  logic [DW-1:0] dv_nxt [NL][QB+1];
  logic [QB-1:0] qt_r [NL][QB+2];
  logic [QB-1:0] qt_nxt [NL][QB+2];
  logic          ov_r [NL][QB+2];
  logic          ov_nxt [NL][QB+2];
  logic          ng_r [NL][QB+2];
  logic          ng_nxt [NL][QB+2];
  logic          nz_r [NL][QB+2];
  logic          nz_nxt [NL][QB+2];
  crd_t          bs_r [NL][QB+2];
  crd_t          bs_nxt [NL][QB+2];

  crd_t          cd_r [NL];
  crd_t          cd_nxt [NL];
  logic [NL-1:0] cok_r;
  logic [NL-1:0] cok_nxt;

  logic [SW-1:0]        sm [NUM_CANDS];
  logic [NUM_CANDS-1:0] sok;
  logic [SW-1:0]        ma_r;
  logic [SW-1:0]        ma_nxt;
  logic [SW-1:0]        mb_r;
  logic [SW-1:0]        mb_nxt;
  logic                 mbok_r;
  logic                 mbok_nxt;
  logic [SW-1:0]        out_r;

  assign adv         = !vld_r[V_OUT] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[V_OUT-1:0], in_ch.valid};
    end
  end

  always_comb begin
    int                  ia;
    int                  ib;
    int                  ic;
    int                  id;
    int                  p;
    logic signed [W-1:0] ux;
    logic signed [W-1:0] uy;
    logic signed [W-1:0] vx;
    logic signed [W-1:0] vy;
    logic signed [2*W-1:0] m0;
    logic signed [2*W-1:0] m1;
    logic [X-1:0]        tm;
    logic [W-1:0]        dlm;
    logic [PW-1:0]       prod;
    logic [RW-1:0]       dsh;
    logic                ge;
    logic [QB-1:0]       qf;
    logic signed [VW-1:0] v;
    logic [SW-1:0]       a01;
    logic [SW-1:0]       a23;

    // cross products of each line pair
    for (int k = 0; k < NUM_PAIRS; k++) begin
      ia = pair_pt(k, 0);
      ib = pair_pt(k, 1);
      ic = pair_pt(k, 2);
      id = pair_pt(k, 3);
      ux = W'(pdx_r[0][ia]) - W'(pdx_r[0][ib]);
      uy = W'(pdy_r[0][ia]) - W'(pdy_r[0][ib]);
      vx = W'(pdx_r[0][ic]) - W'(pdx_r[0][id]);
      vy = W'(pdy_r[0][ic]) - W'(pdy_r[0][id]);
      m0 = ux * vy;
      m1 = uy * vx;
      den1_nxt[k] = X'(m0) - X'(m1);
      ux = W'(pdx_r[0][ic]) - W'(pdx_r[0][ia]);
      uy = W'(pdy_r[0][ic]) - W'(pdy_r[0][ia]);
      vx = W'(pdx_r[0][id]) - W'(pdx_r[0][ia]);
      vy = W'(pdy_r[0][id]) - W'(pdy_r[0][ia]);
      m0 = ux * vy;
      m1 = uy * vx;
      t1_nxt[k] = X'(m0) - X'(m1);
      dl1_nxt[2*k]   = W'(pdx_r[0][ib]) - W'(pdx_r[0][ia]);
      dl1_nxt[2*k+1] = W'(pdy_r[0][ib]) - W'(pdy_r[0][ia]);
      bs1_nxt[2*k]   = pdx_r[0][ia];
      bs1_nxt[2*k+1] = pdy_r[0][ia];
    end

    for (int l = 0; l < NL; l++) begin
      p = l >> 1;
      // magnitudes and split product |delta| * |t|
      tm     = t1_r[p][X-1] ? X'(-t1_r[p]) : X'(t1_r[p]);
      dlm    = dl1_r[l][W-1] ? W'(-dl1_r[l]) : W'(dl1_r[l]);
      dm2_nxt[l] = den1_r[p][X-1] ? X'(-den1_r[p]) : X'(den1_r[p]);
      pl2_nxt[l] = dlm * tm[TL-1:0];
      ph2_nxt[l] = dlm * tm[X-1:TL];
      ng2_nxt[l] = dl1_r[l][W-1] ^ t1_r[p][X-1] ^ den1_r[p][X-1];
      nz2_nxt[l] = den1_r[p] != '0;

      // rounding: floor((2*|delta*t| + |den|) / (2*|den|))
      prod = (PW'(ph2_r[l]) << TL) + PW'(pl2_r[l]);
      rem_nxt[l][0] = RW'({prod, 1'b0}) + RW'(dm2_r[l]);
      dv_nxt[l][0]  = {dm2_r[l], 1'b0};
      qt_nxt[l][0]  = '0;
      ov_nxt[l][0]  = 1'b0;
      ng_nxt[l][0]  = ng2_r[l];
      nz_nxt[l][0]  = nz2_r[l];
      bs_nxt[l][0]  = bs2_r[l];

      // restoring division, first step only flags a quotient too wide
      for (int j = 0; j <= QB; j++) begin
        dsh = RW'(dv_r[l][j]) << (QB - j);
        ge  = rem_r[l][j] >= dsh;
        if (j < QB) begin
          rem_nxt[l][j+1] = ge ? rem_r[l][j] - dsh : rem_r[l][j];
          dv_nxt[l][j+1]  = dv_r[l][j];
        end
        qt_nxt[l][j+1] = qt_r[l][j] | (QB'(ge) << (QB - j));
        ov_nxt[l][j+1] = (j == 0) ? ge : ov_r[l][j];
        ng_nxt[l][j+1] = ng_r[l][j];
        nz_nxt[l][j+1] = nz_r[l][j];
        bs_nxt[l][j+1] = bs_r[l][j];
      end

      qf = qt_r[l][QB+1];
      v  = ng_r[l][QB+1] ? VW'(bs_r[l][QB+1]) - VW'(qf) : VW'(bs_r[l][QB+1]) + VW'(qf);
      cok_nxt[l] = !ov_r[l][QB+1] && nz_r[l][QB+1] && (qf <= QLIM) &&
                   (v >= VMIN) && (v <= VMAX);
      cd_nxt[l]  = v[C-1:0];
    end

    // the four point candidates are always there
    a01    = (sm[1] < sm[0]) ? sm[1] : sm[0];
    a23    = (sm[3] < sm[2]) ? sm[3] : sm[2];
    ma_nxt = (a23 < a01) ? a23 : a01;
    mb_nxt   = '1;
    mbok_nxt = 1'b0;
    for (int k = NUM_PTS; k < NUM_CANDS; k++) begin
      if (sok[k] && (!mbok_nxt || sm[k] < mb_nxt)) begin
        mb_nxt   = sm[k];
        mbok_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pdx_r[0] <= '{in_ch.x0, in_ch.x1, in_ch.x2, in_ch.x3};
      pdy_r[0] <= '{in_ch.y0, in_ch.y1, in_ch.y2, in_ch.y3};
      for (int k = 1; k <= V_CAND; k++) begin
        pdx_r[k] <= pdx_r[k-1];
        pdy_r[k] <= pdy_r[k-1];
      end
      den1_r <= den1_nxt;
      t1_r   <= t1_nxt;
      dl1_r  <= dl1_nxt;
      bs1_r  <= bs1_nxt;
      pl2_r  <= pl2_nxt;
      ph2_r  <= ph2_nxt;
      dm2_r  <= dm2_nxt;
      ng2_r  <= ng2_nxt;
      nz2_r  <= nz2_nxt;
      bs2_r  <= bs1_r;
      rem_r  <= rem_nxt;
      dv_r   <= dv_nxt;
      qt_r   <= qt_nxt;
      ov_r   <= ov_nxt;
      ng_r   <= ng_nxt;
      nz_r   <= nz_nxt;
      bs_r   <= bs_nxt;
      cd_r   <= cd_nxt;
      cok_r  <= cok_nxt;
      ma_r   <= ma_nxt;
      mb_r   <= mb_nxt;
      mbok_r <= mbok_nxt;
      out_r  <= (mbok_r && mb_r < ma_r) ? mb_r : ma_r;
    end
  end

  for (genvar c = 0; c < NUM_CANDS; c++) begin : g_cand
    if (c < NUM_PTS) begin : g_pt
      mds4_dsum #(
        .COORD_BITS(C)
      ) u_dsum (
        .clk    (clk),
        .en     (adv),
        .cand_x (pdx_r[V_CAND][c]),
        .cand_y (pdy_r[V_CAND][c]),
        .pt_x   (pdx_r[V_CAND]),
        .pt_y   (pdy_r[V_CAND]),
        .ok_in  (1'b1),
        .sum    (sm[c]),
        .ok_out (sok[c])
      );
    end else begin : g_cross
      mds4_dsum #(
        .COORD_BITS(C)
      ) u_dsum (
        .clk    (clk),
        .en     (adv),
        .cand_x (cd_r[2*(c-NUM_PTS)]),
        .cand_y (cd_r[2*(c-NUM_PTS)+1]),
        .pt_x   (pdx_r[V_CAND]),
        .pt_y   (pdy_r[V_CAND]),
        .ok_in  (cok_r[2*(c-NUM_PTS)] & cok_r[2*(c-NUM_PTS)+1]),
        .sum    (sm[c]),
        .ok_out (sok[c])
      );
    end
  end

  assign out_ch.valid          = vld_r[V_OUT];
  assign out_ch.total_distance = out_r;

endmodule

// File: src/mds4_dsum.sv
// ----------------------------------------------------------------------------
// mds4_dsum
// Pipelined sum of the four floor distances from one candidate point.
// ----------------------------------------------------------------------------
module mds4_dsum #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] cand_x,
  input  logic signed [COORD_BITS-1:0] cand_y,
  input  logic signed [COORD_BITS-1:0] pt_x [mds4_pkg::NUM_PTS],
  input  logic signed [COORD_BITS-1:0] pt_y [mds4_pkg::NUM_PTS],
  input  logic                         ok_in,
  output logic [COORD_BITS+2:0]        sum,
  output logic                         ok_out
);
  import mds4_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int R   = C + 1;      // root bits
  localparam int NB  = 2 * C + 1;  // squared distance bits
  localparam int TW  = 2 * C + 2;  // trial compare width
  localparam int LAT = dsum_lat(C);

  logic [LAT-1:0] ok_r;
  logic [C-1:0]   ax_r [NUM_PTS];
  logic [C-1:0]   ay_r [NUM_PTS];
  logic [C-1:0]   ax_nxt [NUM_PTS];
  logic [C-1:0]   ay_nxt [NUM_PTS];
  logic [2*C-1:0] sqx_r [NUM_PTS];
  logic [2*C-1:0] sqy_r [NUM_PTS];
  logic [NB-1:0]  rem_r [R][NUM_PTS];
  logic [NB-1:0]  rem_nxt [R][NUM_PTS];
  logic [R-1:0]   root_r [R+1][NUM_PTS];
  logic [R-1:0]   root_nxt [R+1][NUM_PTS];
  logic [R:0]     p01_r;
  logic [R:0]     p23_r;
  logic [R+1:0]   sum_r;

  always_comb begin
    logic signed [C:0] dx;
    logic signed [C:0] dy;
    logic [TW-1:0]     trial;
    logic              ge;
    int                ib;
    for (int i = 0; i < NUM_PTS; i++) begin
      dx = (C+1)'(cand_x) - (C+1)'(pt_x[i]);
      dy = (C+1)'(cand_y) - (C+1)'(pt_y[i]);
      ax_nxt[i] = dx[C] ? C'(-dx) : C'(dx);
      ay_nxt[i] = dy[C] ? C'(-dy) : C'(dy);
      rem_nxt[0][i]  = NB'(sqx_r[i]) + NB'(sqy_r[i]);
      root_nxt[0][i] = '0;
      // one root bit per stage, most significant first
      for (int k = 0; k < R; k++) begin
        ib    = R - 1 - k;
        trial = (TW'(root_r[k][i]) << (ib + 1)) + (TW'(1) << (2 * ib));
        ge    = TW'(rem_r[k][i]) >= trial;
        if (k < R - 1) begin
          rem_nxt[k+1][i] = ge ? NB'(TW'(rem_r[k][i]) - trial) : rem_r[k][i];
        end
        root_nxt[k+1][i] = root_r[k][i] | (R'(ge) << ib);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r <= {ok_r[LAT-2:0], ok_in};
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      for (int i = 0; i < NUM_PTS; i++) begin
        sqx_r[i] <= ax_r[i] * ax_r[i];
        sqy_r[i] <= ay_r[i] * ay_r[i];
      end
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      p01_r  <= (R+1)'(root_r[R][0]) + (R+1)'(root_r[R][1]);
      p23_r  <= (R+1)'(root_r[R][2]) + (R+1)'(root_r[R][3]);
      sum_r  <= (R+2)'(p01_r) + (R+2)'(p23_r);
    end
  end

  assign sum    = sum_r;
  assign ok_out = ok_r[LAT-1];

endmodule

// File: src/mds4_chk.sv
// ----------------------------------------------------------------------------
// mds4_chk
// Port-level checks for the least distance sum engine, bound to the top.
// ----------------------------------------------------------------------------
module mds4_chk #(
  parameter int OUT_BITS = 19
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [OUT_BITS-1:0] total_distance
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // and keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(total_distance))
    else $error("result changed while stalled");

  // input only blocks behind a stalled result
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind min_distance_sum_four_points mds4_chk #(
  .OUT_BITS(COORD_BITS + 3)
) u_mds4_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .total_distance (out_ch.total_distance)
);

// File: bench/mds4_checker.sv
// ----------------------------------------------------------------------------
// mds4_checker
// Watches the point set and result channels, predicts the least distance sum
// of every accepted point set and compares it with the result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mds4_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  logic signed [COORD_BITS-1:0] in_pts [8],
  input  logic out_valid,
  input  logic out_ready,
  input  logic [COORD_BITS+2:0] out_total,
  output int   fail_count,
  output int   pending
);

  typedef logic signed [63:0] s64_t;

  logic [COORD_BITS+2:0] expected_sums [$];
  s64_t                  pt_x [4];
  s64_t                  pt_y [4];

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] dist_sum(input s64_t cx, input s64_t cy);
    logic [63:0] s;
    s64_t dx;
    s64_t dy;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      dx = cx - pt_x[i];
      dy = cy - pt_y[i];
      s += floor_root(dx * dx + dy * dy);
    end
    return s;
  endfunction

  // base + delta*t/den rounded half away from zero; 0 when out of range
  function automatic bit crossing_coord(input s64_t base, input s64_t delta, input s64_t t,
                                        input s64_t den, output s64_t res);
    logic [127:0] num;
    logic [127:0] q;
    logic [127:0] ad;
    s64_t lim;
    bit neg;
    lim = s64_t'(1) << (COORD_BITS - 1);
    neg = ((delta < 0) != (t < 0)) != (den < 0);
    ad = 128'(den < 0 ? -den : den);
    num = 128'(delta < 0 ? -delta : delta) * 128'(t < 0 ? -t : t);
    q = (2 * num + ad) / (2 * ad);
    if (q > (128'd1 << (COORD_BITS + 1))) return 0;
    res = neg ? base - s64_t'(q) : base + s64_t'(q);
    return !(res < -lim || res > lim - 1);
  endfunction

  function automatic logic [COORD_BITS+2:0] least_sum(input logic signed [COORD_BITS-1:0] p [8]);
    logic [63:0] best;
    logic [63:0] s;
    int   ia, ib, ic, id;
    s64_t den, t, cx, cy;
    for (int i = 0; i < 4; i++) begin
      pt_x[i] = p[2*i];
      pt_y[i] = p[2*i+1];
    end
    best = '1;
    for (int i = 0; i < 4; i++) begin
      s = dist_sum(pt_x[i], pt_y[i]);
      if (s < best) best = s;
    end
    for (int k = 0; k < 3; k++) begin
      ia = 0;
      ib = (k == 0) ? 1 : (k == 1) ? 2 : 3;
      ic = (k == 1) ? 1 : 2;
      id = (k == 2) ? 1 : 3;
      den = (pt_x[ia] - pt_x[ib]) * (pt_y[ic] - pt_y[id])
          - (pt_y[ia] - pt_y[ib]) * (pt_x[ic] - pt_x[id]);
      t = (pt_x[ic] - pt_x[ia]) * (pt_y[id] - pt_y[ia])
        - (pt_y[ic] - pt_y[ia]) * (pt_x[id] - pt_x[ia]);
      if (den != 0 &&
          crossing_coord(pt_x[ia], pt_x[ib] - pt_x[ia], t, den, cx) &&
          crossing_coord(pt_y[ia], pt_y[ib] - pt_y[ia], t, den, cy)) begin
        s = dist_sum(cx, cy);
        if (s < best) best = s;
      end
    end
    return best[COORD_BITS+2:0];
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) expected_sums.push_back(least_sum(in_pts));
      if (out_valid && out_ready) begin
        if (expected_sums.size() == 0) begin
          $error("unexpected result transaction: total_distance actual %0d", out_total);
          fail_count++;
        end else begin
          if (out_total !== expected_sums[0]) begin
            $error("total_distance mismatch: expected %0d actual %0d",
                   expected_sums[0], out_total);
            fail_count++;
          end
          void'(expected_sums.pop_front());
        end
      end
      pending = expected_sums.size();
    end
  end

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives random and corner point sets through the least distance sum engine
// with random gaps and stalls on both channels; the checker judges results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

  localparam int CB = 16;
  localparam int LAT = 2 * CB + 16;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   hold_sink;
  logic signed [CB-1:0] in_pts [8];

  mds4_in_if  #(.COORD_BITS(CB)) in_ch ();
  mds4_out_if #(.COORD_BITS(CB)) out_ch ();

  min_distance_sum_four_points #(.COORD_BITS(CB)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  assign in_pts = '{in_ch.x0, in_ch.y0, in_ch.x1, in_ch.y1,
                    in_ch.x2, in_ch.y2, in_ch.x3, in_ch.y3};

  mds4_checker #(.COORD_BITS(CB)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_pts    (in_pts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_total (out_ch.total_distance),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [15:0] rnd_coord(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 64)) - 16'd32;
      2: return $urandom_range(0, 1) ? 16'h7fff - 16'($urandom_range(0, 3))
                                      : 16'h8000 + 16'($urandom_range(0, 3));
      default: return 16'($urandom_range(0, 4000)) - 16'd2000;
    endcase
  endfunction

  task automatic send_set(input logic [15:0] p [8]);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    {in_ch.x0, in_ch.y0, in_ch.x1, in_ch.y1, in_ch.x2, in_ch.y2, in_ch.x3, in_ch.y3}
      <= {p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7]};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // collinear / degenerate shapes hit the skipped-crossing cases
  task automatic random_set(output logic [15:0] p [8]);
    int mode;
    int shape;
    mode = $urandom_range(0, 3);
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 8; i++) p[i] = rnd_coord(mode);
    if (shape == 0) begin
      p[2] = p[0] + 16'd3; p[3] = p[1] + 16'd5;
      p[4] = p[0] + 16'd6; p[5] = p[1] + 16'd10;
    end else if (shape == 1) begin
      p[4] = p[0]; p[5] = p[1];
    end else if (shape == 2) begin
      for (int i = 2; i < 8; i++) p[i] = p[i % 2];
    end
  endtask

  initial begin
    logic [15:0] p [8];
    int          seq_len;
    rst_n = 0;
    hold_sink = 0;
    in_ch.valid = 0;
    {in_ch.x0, in_ch.y0, in_ch.x1, in_ch.y1, in_ch.x2, in_ch.y2, in_ch.x3, in_ch.y3} = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    p = '{default: 16'h0000};                          send_set(p);
    p = '{default: 16'hffff};                          send_set(p);
    p = '{default: 16'h7fff};                          send_set(p);
    p = '{default: 16'h8000};                          send_set(p);
    p = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
          16'h8000, 16'h7fff, 16'h7fff, 16'h8000};     send_set(p);
    p = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
          16'h8000, 16'h8000, 16'h7fff, 16'h7fff};     send_set(p);
    p = '{16'h0000, 16'h0000, 16'h0010, 16'h0010,
          16'h0020, 16'h0020, 16'h0030, 16'h0030};     send_set(p);
    p = '{16'h0000, 16'h0000, 16'h0010, 16'h0000,
          16'h0010, 16'h0010, 16'h0000, 16'h0010};     send_set(p);
    p = '{16'h0000, 16'h0000, 16'h0000, 16'h0001,
          16'h7fff, 16'h0000, 16'h7ffe, 16'h0001};     send_set(p);
    p = '{16'h0000, 16'h0000, 16'h0001, 16'h0001,
          16'h0000, 16'h0001, 16'h0001, 16'h0000};     send_set(p);
    p = '{16'h0000, 16'h0000, 16'h0003, 16'h0001,
          16'h0000, 16'h0001, 16'h0003, 16'h0000};     send_set(p);
    p = '{16'h7000, 16'h7000, 16'h7fff, 16'h7ff0,
          16'h7000, 16'h7010, 16'h7fff, 16'h7fff};     send_set(p);
    p = '{16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
          16'h1234, 16'hedcb, 16'h0f0f, 16'hf0f0};     send_set(p);
    idle_input(1);

    // receiver holds off long while sets keep coming
    hold_sink = 1;
    for (int n = 0; n < 800; n++) begin
      if (n == 400) begin
        idle_input(1);
        while (pending != 0) @(posedge clk);
      end
      random_set(p);
      send_set(p);
      if (n > 80) idle_input(gap_len());
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    int g;
    out_ch.ready = 0;
    @(posedge rst_n);
    while (!hold_sink) @(negedge clk);
    repeat (200) @(negedge clk);
    forever begin
      @(negedge clk);
      out_ch.ready <= 1'b1;
      g = $urandom_range(0, 3) == 0 ? gap_len() : 0;
      if (g > 0) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
